// File: src/rtbnh_pkg.sv
package rtbnh_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_NODE_BITS     = 8;
  localparam int DEF_COST_BITS     = 24;

  localparam int NODE_W  = 8;
  localparam int COST_W  = 24;
  localparam int DELTA_W = 25;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_BEST   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2,
    STATUS_MISS = 2'd3
  } status_e;

endpackage

// File: src/rtbnh_ram.sv
module rtbnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: src/route_table_best_next_hop.sv
// Routing table with best next hop selection.
// Input channel: in_valid_i / in_stall_o carry one operation word (add,
// delete, cost update via neighbor, exact lookup, best route). Output
// channel: out_valid_o / out_stall_i carry exactly one result word for each
// input word, in order.
// Every table operation scans the whole entry memory once, one entry per
// cycle through the read port of a single RAM, and the next word is only
// taken after the current word has been scanned and its result posted;
// unused op codes skip the scan.
// Matching entries are rewritten through the write port during the scan;
// an add writes its free slot when the result is posted.
// The result sits in an output register, so the next input word is taken
// while the previous result still waits; if the receiver stalls, the next
// result is held inside until the output register frees up.
// After reset the block runs a clearing pass over every entry of the entry
// memory and keeps in_stall_o high until it is done.
module route_table_best_next_hop
  import rtbnh_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int NODE_BITS     = DEF_NODE_BITS,
  parameter int COST_BITS     = DEF_COST_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                op_i,
  input  logic [NODE_W-1:0]         neighbor_i,
  input  logic [NODE_W-1:0]         destination_i,
  input  logic [COST_W-1:0]         link_cost_in_i,
  input  logic [COST_W-1:0]         total_cost_in_i,
  input  logic signed [DELTA_W-1:0] cost_delta_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic                      found_o,
  output logic [NODE_W-1:0]         next_hop_o,
  output logic [NODE_W-1:0]         route_destination_o,
  output logic [COST_W-1:0]         route_link_cost_o,
  output logic [COST_W-1:0]         route_total_cost_o,
  output logic [COUNT_W-1:0]        updated_count_o
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int KeyW = 2 * NODE_BITS;
  localparam int EntW = 1 + KeyW + 2 * COST_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0]      clr_q, clr_d;
  logic [IdxW-1:0]      iss_q, iss_d;
  logic [IdxW-1:0]      di_q, di_d;
  logic                 dv_q, dv_d;
  op_e                  op_q, op_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [COST_BITS-1:0] lc_q, lc_d;
  logic [COST_BITS-1:0] tc_q, tc_d;
  logic [COST_BITS:0]   delta_q, delta_d;
  logic                 hit_q, hit_d;
  logic                 free_ok_q, free_ok_d;
  logic [IdxW-1:0]      free_idx_q, free_idx_d;
  logic [KeyW-1:0]      best_key_q, best_key_d;
  logic [COST_BITS-1:0] best_lc_q, best_lc_d;
  logic [COST_BITS-1:0] best_tc_q, best_tc_d;
  logic [COUNT_W-1:0]   count_q, count_d;

  logic                 out_valid_q, out_valid_d;
  logic [1:0]           status_q, status_d;
  logic                 found_q, found_d;
  logic [NODE_W-1:0]    hop_q, hop_d;
  logic [NODE_W-1:0]    dst_q, dst_d;
  logic [COST_W-1:0]    olc_q, olc_d;
  logic [COST_W-1:0]    otc_q, otc_d;
  logic [COUNT_W-1:0]   ucnt_q, ucnt_d;

  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic [EntW-1:0]      rd_data;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [EntW-1:0]      wr_data;

  logic [NODE_BITS+NODE_W-1:0]  nb_ext, ds_ext;
  logic [COST_BITS+COST_W-1:0]  lc_ext, tc_ext;
  logic [COST_BITS+DELTA_W-1:0] dl_ext;
  logic [NODE_BITS+NODE_W-1:0]  hop_ext, dst_ext;
  logic [COST_BITS+COST_W-1:0]  olc_ext, otc_ext;

  logic                 ent_v;
  logic [KeyW-1:0]      ent_key;
  logic [NODE_BITS-1:0] ent_nb, ent_ds;
  logic [COST_BITS-1:0] ent_lc, ent_tc;
  logic [COST_BITS+1:0] sum;
  logic [COST_BITS-1:0] new_tc;
  logic                 key_match, nb_match, ds_match, better;

  rtbnh_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign nb_ext = {{NODE_BITS{1'b0}}, neighbor_i};
  assign ds_ext = {{NODE_BITS{1'b0}}, destination_i};
  assign lc_ext = {{COST_BITS{1'b0}}, link_cost_in_i};
  assign tc_ext = {{COST_BITS{1'b0}}, total_cost_in_i};
  assign dl_ext = {{COST_BITS{1'b0}}, cost_delta_i};

  assign hop_ext = {{NODE_W{1'b0}}, best_key_q[KeyW-1 -: NODE_BITS]};
  assign dst_ext = {{NODE_W{1'b0}}, best_key_q[NODE_BITS-1:0]};
  assign olc_ext = {{COST_W{1'b0}}, best_lc_q};
  assign otc_ext = {{COST_W{1'b0}}, best_tc_q};

  assign ent_v   = rd_data[EntW-1];
  assign ent_key = rd_data[EntW-2 -: KeyW];
  assign ent_nb  = ent_key[KeyW-1 -: NODE_BITS];
  assign ent_ds  = ent_key[NODE_BITS-1:0];
  assign ent_lc  = rd_data[2*COST_BITS-1 -: COST_BITS];
  assign ent_tc  = rd_data[COST_BITS-1:0];

  assign sum = {2'b00, ent_tc} + {delta_q[COST_BITS], delta_q};

  always_comb begin
    if (sum[COST_BITS+1]) begin
      new_tc = '0;
    end else if (sum[COST_BITS]) begin
      new_tc = '1;
    end else begin
      new_tc = sum[COST_BITS-1:0];
    end
  end

  assign key_match = ent_v && (ent_key == key_q);
  assign nb_match  = ent_v && (ent_nb == key_q[KeyW-1 -: NODE_BITS]);
  assign ds_match  = ent_v && (ent_ds == key_q[NODE_BITS-1:0]);
  assign better    = !hit_q || (ent_tc < best_tc_q) ||
                     ((ent_tc == best_tc_q) && (ent_nb < best_key_q[KeyW-1 -: NODE_BITS]));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    iss_d       = iss_q;
    di_d        = di_q;
    dv_d        = dv_q;
    op_d        = op_q;
    key_d       = key_q;
    lc_d        = lc_q;
    tc_d        = tc_q;
    delta_d     = delta_q;
    hit_d       = hit_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    best_key_d  = best_key_q;
    best_lc_d   = best_lc_q;
    best_tc_d   = best_tc_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    found_d     = found_q;
    hop_d       = hop_q;
    dst_d       = dst_q;
    olc_d       = olc_q;
    otc_d       = otc_q;
    ucnt_d      = ucnt_q;
    rd_en       = 1'b0;
    rd_addr     = iss_q;
    wr_en       = 1'b0;
    wr_addr     = di_q;
    wr_data     = rd_data;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        if (clr_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_e'(op_i);
          key_d     = {nb_ext[NODE_BITS-1:0], ds_ext[NODE_BITS-1:0]};
          lc_d      = lc_ext[COST_BITS-1:0];
          tc_d      = tc_ext[COST_BITS-1:0];
          delta_d   = dl_ext[COST_BITS:0];
          iss_d     = '0;
          dv_d      = 1'b0;
          hit_d     = 1'b0;
          free_ok_d = 1'b0;
          count_d   = '0;
          if (op_i == OP_ADD || op_i == OP_DELETE || op_i == OP_UPDATE ||
              op_i == OP_LOOKUP || op_i == OP_BEST) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_SCAN: begin
        rd_en = 1'b1;
        dv_d  = 1'b1;
        di_d  = iss_q;
        if (iss_q != LastIdx) begin
          iss_d = iss_q + 1'b1;
        end
        if (dv_q) begin
          unique case (op_q)
            OP_ADD: begin
              if (key_match) begin
                hit_d = 1'b1;
              end
              if (!ent_v && !free_ok_q) begin
                free_ok_d  = 1'b1;
                free_idx_d = di_q;
              end
            end
            OP_DELETE: begin
              if (key_match) begin
                hit_d   = 1'b1;
                wr_en   = 1'b1;
                wr_data = {1'b0, rd_data[EntW-2:0]};
              end
            end
            OP_UPDATE: begin
              if (nb_match) begin
                wr_en   = 1'b1;
                wr_data = {1'b1, ent_key, lc_q, new_tc};
                if (count_q != COUNT_MAX) begin
                  count_d = count_q + 1'b1;
                end
              end
            end
            OP_LOOKUP: begin
              if (key_match && !hit_q) begin
                hit_d      = 1'b1;
                best_key_d = ent_key;
                best_lc_d  = ent_lc;
                best_tc_d  = ent_tc;
              end
            end
            OP_BEST: begin
              if (ds_match && better) begin
                hit_d      = 1'b1;
                best_key_d = ent_key;
                best_lc_d  = ent_lc;
                best_tc_d  = ent_tc;
              end
            end
            default: begin
            end
          endcase
          if (di_q == LastIdx) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = STATUS_OK;
          found_d     = 1'b0;
          hop_d       = '0;
          dst_d       = '0;
          olc_d       = '0;
          otc_d       = '0;
          ucnt_d      = '0;
          unique case (op_q)
            OP_ADD: begin
              if (hit_q) begin
                status_d = STATUS_DUP;
              end else if (!free_ok_q) begin
                status_d = STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = free_idx_q;
                wr_data = {1'b1, key_q, lc_q, tc_q};
              end
            end
            OP_DELETE: begin
              if (!hit_q) begin
                status_d = STATUS_MISS;
              end
            end
            OP_UPDATE: begin
              ucnt_d = count_q;
            end
            OP_LOOKUP, OP_BEST: begin
              if (hit_q) begin
                found_d = 1'b1;
                hop_d   = hop_ext[NODE_W-1:0];
                dst_d   = dst_ext[NODE_W-1:0];
                olc_d   = olc_ext[COST_W-1:0];
                otc_d   = otc_ext[COST_W-1:0];
              end else begin
                status_d = STATUS_MISS;
              end
            end
            default: begin
            end
          endcase
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      iss_q       <= '0;
      di_q        <= '0;
      dv_q        <= 1'b0;
      op_q        <= OP_ADD;
      key_q       <= '0;
      lc_q        <= '0;
      tc_q        <= '0;
      delta_q     <= '0;
      hit_q       <= 1'b0;
      free_ok_q   <= 1'b0;
      free_idx_q  <= '0;
      best_key_q  <= '0;
      best_lc_q   <= '0;
      best_tc_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      found_q     <= 1'b0;
      hop_q       <= '0;
      dst_q       <= '0;
      olc_q       <= '0;
      otc_q       <= '0;
      ucnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_q       <= iss_d;
      di_q        <= di_d;
      dv_q        <= dv_d;
      op_q        <= op_d;
      key_q       <= key_d;
      lc_q        <= lc_d;
      tc_q        <= tc_d;
      delta_q     <= delta_d;
      hit_q       <= hit_d;
      free_ok_q   <= free_ok_d;
      free_idx_q  <= free_idx_d;
      best_key_q  <= best_key_d;
      best_lc_q   <= best_lc_d;
      best_tc_q   <= best_tc_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      found_q     <= found_d;
      hop_q       <= hop_d;
      dst_q       <= dst_d;
      olc_q       <= olc_d;
      otc_q       <= otc_d;
      ucnt_q      <= ucnt_d;
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign found_o             = found_q;
  assign next_hop_o          = hop_q;
  assign route_destination_o = dst_q;
  assign route_link_cost_o   = olc_q;
  assign route_total_cost_o  = otc_q;
  assign updated_count_o     = ucnt_q;

endmodule

// File: src/rtbnh_checker.sv
module rtbnh_checker
  import rtbnh_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic               found_o,
  input logic [COUNT_W-1:0] updated_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accepted word");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == STATUS_OK)
    else $error("hit reported with an error status");

  a_count_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && updated_count_o != '0 |-> !found_o && status_o == STATUS_OK)
    else $error("update count mixed with a lookup result");

endmodule

bind route_table_best_next_hop rtbnh_checker u_rtbnh_checker (.*);

// File: bench/tb_route_table_best_next_hop.sv
`timescale 1ns / 1ps

module tb_route_table_best_next_hop;
  import rtbnh_pkg::*;

  localparam int ROUTE_SLOTS = DEF_TABLE_ENTRIES;
  localparam int CYCLE_LIMIT = 1200000;
  localparam int RANDOM_WORDS = 925;
  localparam int POOL_DEPTH = 16;
  localparam longint COST_CEIL = (longint'(1) << COST_W) - 1;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [NODE_W-1:0] NODE_TOP = '1;
  localparam logic [COST_W-1:0] COST_TOP = '1;
  localparam logic [DELTA_W-1:0] DELTA_MOST_POS = {1'b0, {(DELTA_W-1){1'b1}}};
  localparam logic [DELTA_W-1:0] DELTA_MOST_NEG = {1'b1, {(DELTA_W-1){1'b0}}};
  localparam logic [DELTA_W-1:0] DELTA_MINUS_ONE = '1;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_NOISE} mix_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [NODE_W-1:0]  nb;
    logic [NODE_W-1:0]  ds;
    logic [COST_W-1:0]  lc;
    logic [COST_W-1:0]  tc;
    logic [DELTA_W-1:0] delta;
  } route_word_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [NODE_W-1:0]  next_hop;
    logic [NODE_W-1:0]  dest;
    logic [COST_W-1:0]  lc;
    logic [COST_W-1:0]  tc;
    logic [COUNT_W-1:0] count;
  } route_result_t;

  typedef struct {
    route_word_t   w;
    bit            typed;
    route_result_t res;
  } directed_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [2:0]                op_i;
  logic [NODE_W-1:0]         neighbor_i;
  logic [NODE_W-1:0]         destination_i;
  logic [COST_W-1:0]         link_cost_in_i;
  logic [COST_W-1:0]         total_cost_in_i;
  logic signed [DELTA_W-1:0] cost_delta_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [1:0]                status_o;
  logic                      found_o;
  logic [NODE_W-1:0]         next_hop_o;
  logic [NODE_W-1:0]         route_destination_o;
  logic [COST_W-1:0]         route_link_cost_o;
  logic [COST_W-1:0]         route_total_cost_o;
  logic [COUNT_W-1:0]        updated_count_o;

  logic              route_valid [ROUTE_SLOTS];
  logic [NODE_W-1:0] route_nb [ROUTE_SLOTS];
  logic [NODE_W-1:0] route_ds [ROUTE_SLOTS];
  logic [COST_W-1:0] route_lc [ROUTE_SLOTS];
  logic [COST_W-1:0] route_tc [ROUTE_SLOTS];

  route_result_t route_replies[$];
  directed_row_t directed_rows[$];
  int fail_count = 0;
  int replies_seen = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  route_table_best_next_hop u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .op_i                (op_i),
    .neighbor_i          (neighbor_i),
    .destination_i       (destination_i),
    .link_cost_in_i      (link_cost_in_i),
    .total_cost_in_i     (total_cost_in_i),
    .cost_delta_i        (cost_delta_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .found_o             (found_o),
    .next_hop_o          (next_hop_o),
    .route_destination_o (route_destination_o),
    .route_link_cost_o   (route_link_cost_o),
    .route_total_cost_o  (route_total_cost_o),
    .updated_count_o     (updated_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int find_route(logic [NODE_W-1:0] nb, logic [NODE_W-1:0] ds);
    for (int i = 0; i < ROUTE_SLOTS; i++) begin
      if (route_valid[i] && route_nb[i] == nb && route_ds[i] == ds) return i;
    end
    return -1;
  endfunction

  function automatic route_result_t route_table_apply(route_word_t w);
    route_result_t r;
    int slot;
    int cnt;
    longint sum;
    r = '0;
    r.status = STATUS_OK;
    slot = -1;
    cnt = 0;
    case (w.op)
      OP_ADD: begin
        if (find_route(w.nb, w.ds) >= 0) begin
          r.status = STATUS_DUP;
        end else begin
          for (int i = 0; i < ROUTE_SLOTS; i++) begin
            if (!route_valid[i] && slot < 0) slot = i;
          end
          if (slot < 0) begin
            r.status = STATUS_FULL;
          end else begin
            route_valid[slot] = 1'b1;
            route_nb[slot] = w.nb;
            route_ds[slot] = w.ds;
            route_lc[slot] = w.lc;
            route_tc[slot] = w.tc;
          end
        end
      end
      OP_DELETE: begin
        slot = find_route(w.nb, w.ds);
        if (slot < 0) r.status = STATUS_MISS;
        else route_valid[slot] = 1'b0;
      end
      OP_UPDATE: begin
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
          if (route_valid[i] && route_nb[i] == w.nb) begin
            sum = longint'(route_tc[i]) + longint'($signed(w.delta));
            if (sum < 0) sum = 0;
            else if (sum > COST_CEIL) sum = COST_CEIL;
            route_tc[i] = sum[COST_W-1:0];
            route_lc[i] = w.lc;
            cnt++;
          end
        end
        r.count = (cnt > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cnt);
      end
      OP_LOOKUP, OP_BEST: begin
        if (w.op == OP_LOOKUP) begin
          slot = find_route(w.nb, w.ds);
        end else begin
          for (int i = 0; i < ROUTE_SLOTS; i++) begin
            if (route_valid[i] && route_ds[i] == w.ds) begin
              if (slot < 0) slot = i;
              else if (route_tc[i] < route_tc[slot] ||
                       (route_tc[i] == route_tc[slot] && route_nb[i] < route_nb[slot]))
                slot = i;
            end
          end
        end
        if (slot < 0) begin
          r.status = STATUS_MISS;
        end else begin
          r.found = 1'b1;
          r.next_hop = route_nb[slot];
          r.dest = route_ds[slot];
          r.lc = route_lc[slot];
          r.tc = route_tc[slot];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic route_result_t status_only(status_e s, int cnt);
    route_result_t r;
    r = '0;
    r.status = s;
    r.count = COUNT_W'(cnt);
    return r;
  endfunction

  function automatic route_result_t found_route(logic [NODE_W-1:0] nh, logic [NODE_W-1:0] rd,
                                                logic [COST_W-1:0] lc, logic [COST_W-1:0] tc);
    route_result_t r;
    r = '0;
    r.status = STATUS_OK;
    r.found = 1'b1;
    r.next_hop = nh;
    r.dest = rd;
    r.lc = lc;
    r.tc = tc;
    return r;
  endfunction

  task automatic put_row(input logic [2:0] op, input logic [NODE_W-1:0] nb,
                         input logic [NODE_W-1:0] ds, input logic [COST_W-1:0] lc,
                         input logic [COST_W-1:0] tc, input logic [DELTA_W-1:0] delta,
                         input bit typed, input route_result_t res);
    directed_row_t row;
    row.w.op = op;
    row.w.nb = nb;
    row.w.ds = ds;
    row.w.lc = lc;
    row.w.tc = tc;
    row.w.delta = delta;
    row.typed = typed;
    row.res = res;
    directed_rows = {directed_rows, row};
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("MISMATCH %s", msg);
    fail_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return COST_TOP;
    if (r < 5) return COST_W'($urandom_range(0, 7));
    return COST_W'($urandom());
  endfunction

  function automatic logic [DELTA_W-1:0] pick_delta();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return DELTA_MOST_NEG;
    if (r == 1) return DELTA_MOST_POS;
    if (r < 4) return DELTA_W'($urandom_range(0, 32) - 16);
    return DELTA_W'($urandom());
  endfunction

  function automatic logic [2:0] pick_op(mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 70) return OP_ADD;
        if (r < 78) return OP_LOOKUP;
        if (r < 86) return OP_BEST;
        if (r < 93) return OP_UPDATE;
        return OP_DELETE;
      end
      MIX_CHURN: begin
        if (r < 30) return OP_ADD;
        if (r < 50) return OP_DELETE;
        if (r < 65) return OP_UPDATE;
        if (r < 82) return OP_LOOKUP;
        return OP_BEST;
      end
      MIX_DRAIN: begin
        if (r < 15) return OP_ADD;
        if (r < 65) return OP_DELETE;
        if (r < 75) return OP_UPDATE;
        if (r < 88) return OP_LOOKUP;
        return OP_BEST;
      end
      default: return 3'($urandom_range(0, OP_SPARE_HI));
    endcase
  endfunction

  task automatic send_word(input route_word_t w, input bit typed, input route_result_t res);
    int gap;
    route_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= w.op;
    neighbor_i <= w.nb;
    destination_i <= w.ds;
    link_cost_in_i <= w.lc;
    total_cost_in_i <= w.tc;
    cost_delta_i <= w.delta;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = route_table_apply(w);
    route_replies = {route_replies, (typed ? res : predicted)};
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (route_replies.size() != 0);
  endtask

  always @(posedge clk_i) begin
    route_result_t want;
    int r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (route_replies.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing pending", replies_seen));
      end else begin
        want = route_replies.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("word %0d status %0d, want %0d",
                                    replies_seen, status_o, want.status));
        if (found_o !== want.found)
          report_mismatch($sformatf("word %0d found %0d, want %0d",
                                    replies_seen, found_o, want.found));
        if (next_hop_o !== want.next_hop)
          report_mismatch($sformatf("word %0d next_hop %0h, want %0h",
                                    replies_seen, next_hop_o, want.next_hop));
        if (route_destination_o !== want.dest)
          report_mismatch($sformatf("word %0d route_destination %0h, want %0h",
                                    replies_seen, route_destination_o, want.dest));
        if (route_link_cost_o !== want.lc)
          report_mismatch($sformatf("word %0d route_link_cost %0h, want %0h",
                                    replies_seen, route_link_cost_o, want.lc));
        if (route_total_cost_o !== want.tc)
          report_mismatch($sformatf("word %0d route_total_cost %0h, want %0h",
                                    replies_seen, route_total_cost_o, want.tc));
        if (updated_count_o !== want.count)
          report_mismatch($sformatf("word %0d updated_count %0d, want %0d",
                                    replies_seen, updated_count_o, want.count));
      end
      replies_seen++;
    end
    if (stall_left > 0) begin
      stall_left--;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_route_table_best_next_hop failed");
      $finish;
    end
  end

  initial begin
    route_word_t w;
    mix_e mix;
    int phase_len;
    int nb_n;
    int ds_n;
    int random_words;
    int phase_idx;
    logic [NODE_W-1:0] nb_pool [POOL_DEPTH];
    logic [NODE_W-1:0] ds_pool [POOL_DEPTH];

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    op_i <= OP_ADD;
    neighbor_i <= '0;
    destination_i <= '0;
    link_cost_in_i <= '0;
    total_cost_in_i <= '0;
    cost_delta_i <= '0;
    for (int i = 0; i < ROUTE_SLOTS; i++) route_valid[i] = 1'b0;

    put_row(OP_LOOKUP, '0, '0, '0, '0, '0, 1'b1, status_only(STATUS_MISS, 0));
    put_row(OP_BEST, NODE_TOP, NODE_TOP, '0, '0, '0, 1'b1, status_only(STATUS_MISS, 0));
    put_row(OP_DELETE, NODE_TOP, '0, '0, '0, '0, 1'b1, status_only(STATUS_MISS, 0));
    put_row(OP_UPDATE, '0, '0, COST_TOP, '0, DELTA_MOST_POS, 1'b1, status_only(STATUS_OK, 0));
    put_row(OP_ADD, '0, '0, '0, '0, '0, 1'b1, status_only(STATUS_OK, 0));
    put_row(OP_ADD, '0, '0, COST_TOP, COST_TOP, '0, 1'b1, status_only(STATUS_DUP, 0));
    put_row(OP_ADD, NODE_TOP, NODE_TOP, COST_TOP, COST_TOP, '0, 1'b1,
            status_only(STATUS_OK, 0));
    put_row(OP_LOOKUP, NODE_TOP, NODE_TOP, '0, '0, '0, 1'b1,
            found_route(NODE_TOP, NODE_TOP, COST_TOP, COST_TOP));
    put_row(OP_ADD, 8'd1, NODE_TOP, 24'd5, COST_TOP, '0, 1'b1, status_only(STATUS_OK, 0));
    put_row(OP_BEST, '0, NODE_TOP, '0, '0, '0, 1'b1, found_route(8'd1, NODE_TOP, 24'd5, COST_TOP));
    put_row(OP_UPDATE, NODE_TOP, '0, 24'd7, '0, DELTA_MOST_POS, 1'b1, status_only(STATUS_OK, 1));
    put_row(OP_LOOKUP, NODE_TOP, NODE_TOP, '0, '0, '0, 1'b1,
            found_route(NODE_TOP, NODE_TOP, 24'd7, COST_TOP));
    put_row(OP_UPDATE, NODE_TOP, NODE_TOP, '0, '0, DELTA_MOST_NEG, 1'b1,
            status_only(STATUS_OK, 1));
    put_row(OP_LOOKUP, NODE_TOP, NODE_TOP, '0, '0, '0, 1'b1,
            found_route(NODE_TOP, NODE_TOP, '0, '0));
    put_row(OP_BEST, 8'd1, NODE_TOP, '0, '0, '0, 1'b1, found_route(NODE_TOP, NODE_TOP, '0, '0));
    put_row(OP_UPDATE, '0, '0, 24'd3, '0, DELTA_MINUS_ONE, 1'b0, '0);
    put_row(OP_ADD, 8'd2, '0, 24'd9, '0, '0, 1'b0, '0);
    put_row(OP_BEST, NODE_TOP, '0, '0, '0, '0, 1'b0, '0);
    put_row(OP_UPDATE, 8'd1, '0, 24'd1234, '0, DELTA_W'(-5), 1'b0, '0);
    put_row(OP_DELETE, '0, '0, '0, '0, '0, 1'b1, status_only(STATUS_OK, 0));
    put_row(OP_DELETE, '0, '0, '0, '0, '0, 1'b1, status_only(STATUS_MISS, 0));
    put_row(OP_BEST, '0, '0, '0, '0, '0, 1'b0, '0);
    put_row(OP_SPARE_LO, NODE_TOP, NODE_TOP, COST_TOP, COST_TOP, '1, 1'b1,
            status_only(STATUS_OK, 0));
    put_row(OP_SPARE_HI, NODE_TOP, NODE_TOP, COST_TOP, COST_TOP, '1, 1'b1,
            status_only(STATUS_OK, 0));
    put_row(OP_LOOKUP, 8'd1, NODE_TOP, '0, '0, '0, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_word(directed_rows[i].w, directed_rows[i].typed,
                                         directed_rows[i].res);

    random_words = 0;
    phase_idx = 0;
    while (random_words < RANDOM_WORDS) begin
      if (phase_idx == 0) begin
        mix = MIX_FILL;
        phase_len = 160;
        nb_n = POOL_DEPTH;
        ds_n = 8;
        quiet = 1'b0;
      end else begin
        mix = mix_e'($urandom_range(0, 3));
        phase_len = $urandom_range(40, 120);
        nb_n = $urandom_range(2, POOL_DEPTH);
        ds_n = $urandom_range(2, 8);
        quiet = ($urandom_range(0, 3) == 0);
      end
      for (int i = 0; i < POOL_DEPTH; i++) begin
        nb_pool[i] = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? NODE_TOP : '0)
                                                : NODE_W'($urandom_range(0, 255));
        ds_pool[i] = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? NODE_TOP : '0)
                                                : NODE_W'($urandom_range(0, 255));
      end
      for (int k = 0; k < phase_len && random_words < RANDOM_WORDS; k++) begin
        w.op = pick_op(mix);
        if (mix == MIX_NOISE) begin
          w.nb = NODE_W'($urandom_range(0, 255));
          w.ds = NODE_W'($urandom_range(0, 255));
        end else begin
          w.nb = nb_pool[$urandom_range(0, nb_n - 1)];
          w.ds = ds_pool[$urandom_range(0, ds_n - 1)];
        end
        w.lc = pick_cost();
        w.tc = pick_cost();
        w.delta = pick_delta();
        send_word(w, 1'b0, '0);
        random_words++;
      end
      if (phase_idx == 0 || $urandom_range(0, 2) == 0) hold_until_drained();
      phase_idx++;
    end

    quiet = 1'b0;
    hold_until_drained();
    repeat (ROUTE_SLOTS + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_route_table_best_next_hop passed");
    end else begin
      $display("tb_route_table_best_next_hop failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rtbnh_pkg.sv
src/rtbnh_ram.sv
src/route_table_best_next_hop.sv
src/rtbnh_checker.sv
bench/tb_route_table_best_next_hop.sv
